// ===== hw/rtl/lps_pkg.sv =====
// shared types, mode codes, register indexes and helpers for the landing sequencer
package lps_pkg;

	// landing modes
	localparam logic [3:0] MODE_IDLE     = 4'd0;
	localparam logic [3:0] MODE_PRECHECK = 4'd1;
	localparam logic [3:0] MODE_ACQUIRE  = 4'd2;
	localparam logic [3:0] MODE_ALIGN    = 4'd3;
	localparam logic [3:0] MODE_HIGH     = 4'd4;
	localparam logic [3:0] MODE_FIXEDXY  = 4'd5;
	localparam logic [3:0] MODE_REACQ    = 4'd6;
	localparam logic [3:0] MODE_REQUEST  = 4'd7;
	localparam logic [3:0] MODE_DONE     = 4'd8;
	localparam logic [3:0] MODE_ABORT    = 4'd9;
	localparam logic [3:0] MODE_PASSIVE  = 4'd10;

	// register indexes
	localparam logic [2:0] REG_ACQUIRE_STABLE = 3'd0;
	localparam logic [2:0] REG_ALIGN_STABLE   = 3'd1;
	localparam logic [2:0] REG_LOSS_TIMEOUT   = 3'd2;
	localparam logic [2:0] REG_ALIGN_ERROR    = 3'd3;
	localparam logic [2:0] REG_HIGH_ERROR     = 3'd4;
	localparam logic [2:0] REG_HANDOFF_HEIGHT = 3'd5;
	localparam logic [2:0] REG_FIXED_SPEED    = 3'd6;
	localparam logic [2:0] REG_HIGH_SPEED     = 3'd7;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 20;
	localparam int InDataW  = 80;
	localparam int OutDataW = 32;

	// register reset values
	localparam logic [15:0]        RST_ACQUIRE_STABLE = 16'd1000;
	localparam logic [15:0]        RST_ALIGN_STABLE   = 16'd1000;
	localparam logic [15:0]        RST_LOSS_TIMEOUT   = 16'd1000;
	localparam logic [15:0]        RST_ALIGN_ERROR    = 16'd200;
	localparam logic [15:0]        RST_HIGH_ERROR     = 16'd300;
	localparam logic signed [19:0] RST_HANDOFF_HEIGHT = 20'sd500;
	localparam logic [15:0]        RST_FIXED_SPEED    = 16'd300;
	localparam logic [15:0]        RST_HIGH_SPEED     = 16'd500;

	typedef struct packed {
		logic [15:0]        acquire_stable_ms;
		logic [15:0]        align_stable_ms;
		logic [15:0]        loss_timeout_ms;
		logic [15:0]        align_error_mm;
		logic [15:0]        high_align_error_mm;
		logic signed [19:0] handoff_height_mm;
		logic [15:0]        fixed_descent_speed;
		logic [15:0]        high_descent_speed;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               trigger;
		logic               ap_land_engaged;
		logic               inputs_fresh;
		logic               offboard;
		logic               preflight_pass;
		logic               marker_seen;
		logic [15:0]        horizontal_error_mm;
		logic signed [19:0] marker_height_mm;
		logic               touchdown;
	} item_t;

	typedef struct packed {
		logic [3:0]  landing_mode;
		logic        reset_lock_pulse;
		logic        reset_control_pulse;
		logic        reset_jump_pulse;
		logic [15:0] descent_speed;
		logic        request_land;
		logic        success;
	} res_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] t;
	} stamp_t;

	typedef struct packed {
		logic [3:0] mode;
		stamp_t     visible_since;
		stamp_t     aligned_since;
		stamp_t     loss_since;
		stamp_t     gate_since;
		logic [3:0] gate_mode;
	} state_t;

	localparam stamp_t STAMP_NONE = '{valid: 1'b0, t: 32'd0};

	function automatic stamp_t stamp_at(input logic [31:0] now);
		stamp_t s;
		s.valid = 1'b1;
		s.t     = now;
		return s;
	endfunction

	// wrapping elapsed time against a limit
	function automatic logic held(input stamp_t s, input logic [31:0] now,
		input logic [15:0] lim);
		logic [31:0] d;
		d = now - s.t;
		return d >= {16'd0, lim};
	endfunction

endpackage

// ===== hw/rtl/lps_step.sv =====
// next-state and result logic for one sensor update
module lps_step import lps_pkg::*; (
	input  cfg_t   cfg,
	input  state_t st,
	input  item_t  item,
	output state_t st_nx,
	output res_t   res
);

	logic [15:0] fine_gate;

	assign fine_gate = (cfg.align_error_mm < cfg.high_align_error_mm) ?
		cfg.align_error_mm : cfg.high_align_error_mm;

	always_comb begin
		state_t      nx;
		logic [3:0]  m;
		logic        p_lock;
		logic        p_ctrl;
		logic        p_jump;
		logic        entered;
		logic [15:0] speed;
		logic        above;
		logic        fine_ok;

		nx      = st;
		m       = st.mode;
		p_lock  = 1'b0;
		p_ctrl  = 1'b0;
		p_jump  = 1'b0;
		entered = 1'b0;
		speed   = 16'd0;
		above   = item.marker_height_mm > cfg.handoff_height_mm;
		fine_ok = item.horizontal_error_mm <= fine_gate;

		// trigger dropped or new mission
		if (!item.trigger && (m == MODE_PRECHECK || m == MODE_ACQUIRE ||
			m == MODE_ABORT || m == MODE_PASSIVE || m == MODE_DONE)) begin
			m                = MODE_IDLE;
			nx.visible_since = STAMP_NONE;
			nx.aligned_since = STAMP_NONE;
			nx.loss_since    = STAMP_NONE;
			nx.gate_since    = STAMP_NONE;
			nx.gate_mode     = MODE_IDLE;
			p_lock           = 1'b1;
		end else if (m == MODE_IDLE && item.trigger) begin
			m       = MODE_PRECHECK;
			entered = 1'b1;
		end

		priority if (entered) begin
			// nothing more on the entry step
		end else if (m == MODE_REQUEST && item.ap_land_engaged) begin
			m = MODE_DONE;
		end else if (m != MODE_IDLE && m != MODE_PRECHECK && m != MODE_PASSIVE &&
			m != MODE_DONE && !item.inputs_fresh) begin
			m = MODE_ABORT;
		end else if (m != MODE_IDLE && m != MODE_PASSIVE && m != MODE_DONE &&
			!item.offboard) begin
			m = MODE_PASSIVE;
		end else if (m == MODE_PRECHECK && item.preflight_pass && item.offboard) begin
			m                = MODE_ACQUIRE;
			nx.visible_since = item.marker_seen ? stamp_at(item.now_ms) : STAMP_NONE;
		end else if (m == MODE_ACQUIRE) begin
			priority if (!item.marker_seen) begin
				nx.visible_since = STAMP_NONE;
			end else if (!nx.visible_since.valid) begin
				nx.visible_since = stamp_at(item.now_ms);
			end else if (held(nx.visible_since, item.now_ms, cfg.acquire_stable_ms)) begin
				m                = MODE_ALIGN;
				nx.aligned_since = fine_ok ? stamp_at(item.now_ms) : STAMP_NONE;
			end else begin
			end
		end else if (m == MODE_FIXEDXY) begin
			if (item.touchdown)
				m = MODE_REQUEST;
		end else if (m == MODE_ALIGN || m == MODE_HIGH) begin
			if (!item.marker_seen) begin
				if (!nx.loss_since.valid) begin
					nx.loss_since = stamp_at(item.now_ms);
					p_ctrl        = 1'b1;
				end
				nx.gate_since = STAMP_NONE;
				nx.gate_mode  = MODE_IDLE;
				if (held(nx.loss_since, item.now_ms, cfg.loss_timeout_ms)) begin
					m      = MODE_REACQ;
					p_ctrl = 1'b1;
					p_jump = 1'b1;
				end
			end else begin
				nx.loss_since = STAMP_NONE;
				priority if (!above) begin
					m             = MODE_FIXEDXY;
					nx.gate_since = STAMP_NONE;
					nx.gate_mode  = MODE_IDLE;
				end else if (m == MODE_ALIGN) begin
					priority if (!fine_ok) begin
						nx.aligned_since = STAMP_NONE;
					end else if (!nx.aligned_since.valid) begin
						nx.aligned_since = stamp_at(item.now_ms);
					end else if (held(nx.aligned_since, item.now_ms,
						cfg.align_stable_ms)) begin
						m             = MODE_HIGH;
						nx.gate_mode  = MODE_HIGH;
						nx.gate_since = nx.aligned_since;
					end else begin
					end
				end else begin
					priority if (item.horizontal_error_mm > cfg.high_align_error_mm) begin
						nx.gate_since = STAMP_NONE;
					end else if (nx.gate_mode != m || !nx.gate_since.valid) begin
						nx.gate_mode  = m;
						nx.gate_since = stamp_at(item.now_ms);
					end else begin
					end
				end
			end
		end else if (m == MODE_REACQ) begin
			if (item.marker_seen) begin
				m                = MODE_ALIGN;
				nx.loss_since    = STAMP_NONE;
				nx.aligned_since = fine_ok ? stamp_at(item.now_ms) : STAMP_NONE;
				nx.gate_since    = STAMP_NONE;
				nx.gate_mode     = MODE_IDLE;
				p_ctrl           = 1'b1;
			end
		end else begin
		end

		nx.mode = m;

		// commanded descent speed
		priority if (m == MODE_FIXEDXY) begin
			speed = cfg.fixed_descent_speed;
		end else if (m == MODE_HIGH && item.marker_seen && above &&
			item.horizontal_error_mm <= cfg.high_align_error_mm &&
			nx.gate_mode == m && nx.gate_since.valid &&
			held(nx.gate_since, item.now_ms, cfg.align_stable_ms)) begin
			speed = cfg.high_descent_speed;
		end else begin
			speed = 16'd0;
		end

		st_nx                   = nx;
		res.landing_mode        = m;
		res.reset_lock_pulse    = p_lock;
		res.reset_control_pulse = p_ctrl;
		res.reset_jump_pulse    = p_jump;
		res.descent_speed       = speed;
		res.request_land        = (m == MODE_REQUEST);
		res.success             = (m == MODE_DONE);
	end

endmodule

// ===== hw/rtl/landing_phase_sequencer.sv =====
// landing phase sequencer top level: input register, step logic, result register
//
// channel  | dir | handshake         | payload
// s_*      | in  | s_tvalid/s_tready | s_tdata: one sensor update word
// m_*      | out | m_tvalid/m_tready | m_tdata: one mode/command word per update
// cfg_*    | in  | cfg_we            | cfg_index, cfg_data: register write
//
// a word taken into the input register is stepped into the result register when
// the result register is free or being drained, and its result is offered on m_*
// one update per cycle sustained while m_tready is high; the mode and since-time
// registers close the loop via the step logic, so consecutive words chain directly
// arst_n clears mode, since-times, valids and the registers to their defaults
// a stalled result holds in the result register while the input register still
// takes one more word; s_tready drops only when both are full and m_tready is low
module landing_phase_sequencer import lps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// slave side
	input  logic                s_tvalid,
	output logic                s_tready,
	// [31:0] now_ms, [32] trigger, [33] ap_land_engaged, [34] inputs_fresh,
	// [35] offboard, [36] preflight_pass, [37] marker_seen,
	// [53:38] horizontal_error_mm, [73:54] marker_height_mm,
	// [74] touchdown, [79:75] zero
	input  logic [InDataW-1:0]  s_tdata,
	// master side
	output logic                m_tvalid,
	input  logic                m_tready,
	// [3:0] landing_mode, [4] reset_lock_pulse, [5] reset_control_pulse,
	// [6] reset_jump_pulse, [22:7] descent_speed, [23] request_land,
	// [24] success, [31:25] zero
	output logic [OutDataW-1:0] m_tdata,
	// configuration writes
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t   cfg_q;
	state_t st_q;
	state_t st_nx;
	item_t  item_in;
	item_t  item_s1;
	logic   valid_s1;
	res_t   res_nx;
	res_t   res_s2;
	logic   valid_s2;
	logic   adv;

	// unpack the incoming word
	assign item_in.now_ms              = s_tdata[31:0];
	assign item_in.trigger             = s_tdata[32];
	assign item_in.ap_land_engaged     = s_tdata[33];
	assign item_in.inputs_fresh        = s_tdata[34];
	assign item_in.offboard            = s_tdata[35];
	assign item_in.preflight_pass      = s_tdata[36];
	assign item_in.marker_seen         = s_tdata[37];
	assign item_in.horizontal_error_mm = s_tdata[53:38];
	assign item_in.marker_height_mm    = s_tdata[73:54];
	assign item_in.touchdown           = s_tdata[74];

	// step fires when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.acquire_stable_ms   <= RST_ACQUIRE_STABLE;
			cfg_q.align_stable_ms     <= RST_ALIGN_STABLE;
			cfg_q.loss_timeout_ms     <= RST_LOSS_TIMEOUT;
			cfg_q.align_error_mm      <= RST_ALIGN_ERROR;
			cfg_q.high_align_error_mm <= RST_HIGH_ERROR;
			cfg_q.handoff_height_mm   <= RST_HANDOFF_HEIGHT;
			cfg_q.fixed_descent_speed <= RST_FIXED_SPEED;
			cfg_q.high_descent_speed  <= RST_HIGH_SPEED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACQUIRE_STABLE: cfg_q.acquire_stable_ms   <= cfg_data[15:0];
				REG_ALIGN_STABLE:   cfg_q.align_stable_ms     <= cfg_data[15:0];
				REG_LOSS_TIMEOUT:   cfg_q.loss_timeout_ms     <= cfg_data[15:0];
				REG_ALIGN_ERROR:    cfg_q.align_error_mm      <= cfg_data[15:0];
				REG_HIGH_ERROR:     cfg_q.high_align_error_mm <= cfg_data[15:0];
				REG_HANDOFF_HEIGHT: cfg_q.handoff_height_mm   <= cfg_data[19:0];
				REG_FIXED_SPEED:    cfg_q.fixed_descent_speed <= cfg_data[15:0];
				REG_HIGH_SPEED:     cfg_q.high_descent_speed  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_in;
	end

	lps_step u_step (
		.cfg   (cfg_q),
		.st    (st_q),
		.item  (item_s1),
		.st_nx (st_nx),
		.res   (res_nx)
	);

	// sequencer state, updated once per stepped word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode          <= MODE_IDLE;
			st_q.visible_since <= STAMP_NONE;
			st_q.aligned_since <= STAMP_NONE;
			st_q.loss_since    <= STAMP_NONE;
			st_q.gate_since    <= STAMP_NONE;
			st_q.gate_mode     <= MODE_IDLE;
		end else if (adv) begin
			st_q <= st_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_nx;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.success, res_s2.request_land, res_s2.descent_speed,
		res_s2.reset_jump_pulse, res_s2.reset_control_pulse, res_s2.reset_lock_pulse,
		res_s2.landing_mode};

endmodule

// ===== hw/rtl/lps_checker.sv =====
// port-level checks for the landing sequencer and their binding
module lps_checker import lps_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// with the result side empty the input side is never blocked
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// request and success flags follow the mode
	a_flags_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23] == (m_tdata[3:0] == MODE_REQUEST)) &&
			(m_tdata[24] == (m_tdata[3:0] == MODE_DONE)))
		else $error("request or success flag disagrees with mode");

	// descent speed only in a descent mode, lock reset only on return to idle
	a_speed_lock: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[22:7] == 16'd0) || (m_tdata[3:0] == MODE_HIGH) ||
			(m_tdata[3:0] == MODE_FIXEDXY)) &&
			(!m_tdata[4] || (m_tdata[3:0] == MODE_IDLE)))
		else $error("speed or lock pulse outside its mode");

endmodule

bind landing_phase_sequencer lps_checker u_lps_checker (.*);
